FILE: design/assert_macros.svh
// Assertion macros used by the cache core RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

FILE: design/lkvc_pkg.sv
// Shared constants and types of the LRU key/value cache core.
// No dependencies; used by lkvc_cell and lru_key_value_cache_core.
`timescale 1ns / 1ps

package lkvc_pkg;

    localparam int DATA_W      = 32;
    localparam int CAP_W       = 5;
    localparam int ENTRIES_DEF = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic cmp;
        logic upd;
        logic put;
        logic hit;
        logic full;
    } lkvc_ctl_t;

    typedef struct packed {
        logic              hit;
        logic              taken;
        logic [DATA_W-1:0] value;
    } lkvc_chain_t;

endpackage

FILE: design/lkvc_cell.sv
// One cache entry: valid bit, key, value, recency age and match flag.
// Depends on lkvc_pkg; chained by lru_key_value_cache_core.
`timescale 1ns / 1ps

module lkvc_cell #(
    parameter int AGE_W = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lkvc_pkg::lkvc_ctl_t         ctl,
    input  logic [lkvc_pkg::DATA_W-1:0] req_key,
    input  logic [lkvc_pkg::DATA_W-1:0] req_value,
    input  logic [AGE_W-1:0]            hit_age,
    input  logic [AGE_W-1:0]            victim_age,
    input  lkvc_pkg::lkvc_chain_t       chain_in,
    output lkvc_pkg::lkvc_chain_t       chain_out,
    input  logic [AGE_W-1:0]            age_in,
    output logic [AGE_W-1:0]            age_out,
    output logic                        match
);
    import lkvc_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [AGE_W-1:0]  age_reg;
    logic [AGE_W-1:0]  age_next;
    logic              match_reg;
    logic              match_next;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] value_reg;
    logic              take_free;
    logic              victim;
    logic              target;
    logic              act;
    logic              grow;

    assign take_free = !valid_reg && !chain_in.taken;
    assign victim    = valid_reg && (age_reg == victim_age);
    assign target    = ctl.hit ? match_reg : (ctl.full ? victim : take_free);
    assign act       = ctl.upd && (ctl.hit || ctl.put);
    assign grow      = valid_reg && (!ctl.hit || (age_reg < hit_age));

    assign chain_out.hit   = chain_in.hit | match_reg;
    assign chain_out.taken = chain_in.taken | !valid_reg;
    assign chain_out.value = chain_in.value | (match_reg ? value_reg : '0);
    assign age_out         = age_in | (match_reg ? age_reg : '0);
    assign match           = match_reg;

    always_comb
    begin
        match_next = match_reg;
        valid_next = valid_reg;
        age_next   = age_reg;
        if (ctl.cmp)
        begin
            match_next = valid_reg && (key_reg == req_key);
        end
        if (act)
        begin
            if (target)
            begin
                valid_next = 1'b1;
                age_next   = '0;
            end
            else if (grow)
            begin
                age_next = age_reg + AGE_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            age_reg   <= '0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            age_reg   <= age_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (act && target && ctl.put)
        begin
            key_reg   <= req_key;
            value_reg <= req_value;
        end
    end

endmodule

FILE: design/lru_key_value_cache_core.sv
// Top level of the fully associative LRU key/value cache: control and cell row.
// Depends on lkvc_pkg, lkvc_cell and assert_macros.svh.
//
//   channel   handshake          payload
//   request   start / busy       op, lookup_key, write_value
//   result    done (strobe)      found, read_value
//   config    cfg_wr_en          cfg_wr_data (capacity)
//
// A request has a compare cycle (busy high) in which every cell
// matches the key, then an update cycle in which the cells update ages, keys
// and values; the next request may be accepted in the update cycle.
// The result strobe follows the update cycle. Reset clears valid bits, ages,
// occupancy and sets capacity to 16. The receiver cannot stall results.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lru_key_value_cache_core #(
    parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               op,
    input  logic signed [lkvc_pkg::DATA_W-1:0] lookup_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0] write_value,
    output logic                               done,
    output logic                               found,
    output logic signed [lkvc_pkg::DATA_W-1:0] read_value,
    input  logic                               cfg_wr_en,
    input  logic [lkvc_pkg::CAP_W-1:0]         cfg_wr_data
);
    import lkvc_pkg::*;

    localparam int AGE_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CAP_W > OCC_W) ? CAP_W : OCC_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [CAP_W-1:0]  cap_reg;
    logic [OCC_W-1:0]  occ_reg;
    logic [OCC_W-1:0]  occ_next;
    logic              op_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] value_reg;
    logic              done_reg;
    logic              found_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic              accept;
    logic [CAP_W-1:0]  cap_min1;
    logic              full;
    logic [AGE_W-1:0]  victim_age;
    logic              upd;
    logic              hit;
    lkvc_ctl_t         ctl;
    lkvc_chain_t       chain [ENTRIES+1];
    logic [AGE_W-1:0]  age_chain [ENTRIES+1];
    logic [ENTRIES-1:0] match_vec;

    assign busy   = (state_reg == ST_CMP);
    assign accept = start && !busy;
    assign upd    = (state_reg == ST_UPD);

    assign cap_min1   = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
    assign full       = (CMP_W'(occ_reg) >= CMP_W'(cap_min1)) || (occ_reg == OCC_W'(ENTRIES));
    assign victim_age = AGE_W'(occ_reg - OCC_W'(1));

    assign chain[0]     = '{hit: 1'b0, taken: 1'b0, value: '0};
    assign age_chain[0] = '0;
    assign hit          = chain[ENTRIES].hit;

    assign ctl.cmp  = (state_reg == ST_CMP);
    assign ctl.upd  = upd;
    assign ctl.put  = (op_reg == OP_PUT);
    assign ctl.hit  = hit;
    assign ctl.full = full;

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        lkvc_cell #(
            .AGE_W(AGE_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .req_key   (key_reg),
            .req_value (value_reg),
            .hit_age   (age_chain[ENTRIES]),
            .victim_age(victim_age),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .age_in    (age_chain[i]),
            .age_out   (age_chain[i+1]),
            .match     (match_vec[i])
        );
    end

    always_comb
    begin
        state_next = ST_IDLE;
        if (accept)
        begin
            state_next = ST_CMP;
        end
        else if (state_reg == ST_CMP)
        begin
            state_next = ST_UPD;
        end
        occ_next = occ_reg;
        if (upd && (op_reg == OP_PUT) && !hit && !full)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cap_reg   <= CAP_RESET;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            done_reg  <= upd;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            key_reg   <= lookup_key;
            value_reg <= write_value;
        end
        if (upd)
        begin
            found_reg      <= hit;
            read_value_reg <= (hit && (op_reg == OP_GET)) ? chain[ENTRIES].value : MISS_VALUE;
        end
    end

    assign done       = done_reg;
    assign found      = found_reg;
    assign read_value = read_value_reg;

    `ASSERT_NEVER(a_occ_bound, clk, rst_n, occ_reg > OCC_W'(ENTRIES))
    `ASSERT_CLK(a_upd_done, clk, rst_n, (state_reg == ST_UPD) |=> done_reg)
    `ASSERT_CLK(a_one_match, clk, rst_n, $onehot0(match_vec))
    `ASSERT_CLK(a_miss_value, clk, rst_n, (done_reg && !found_reg) |-> (read_value_reg == MISS_VALUE))
    `ASSERT_CLK(a_occ_step, clk, rst_n, (occ_reg != $past(occ_reg)) |-> $past(state_reg == ST_UPD))

endmodule

FILE: dv/tb.sv
// Self-checking testbench for lru_key_value_cache_core: a directed table, then random
// get/put traffic over several capacities, checked against an in-bench LRU predictor.
// Depends on lkvc_pkg and the cache core RTL.
`timescale 1ns / 1ps

module tb;

    import lkvc_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEF;
    localparam int WDOG_LIMIT  = 2000;
    localparam int SETTLE      = 4;
    localparam int DRAIN       = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_REQS  = 50;
    localparam int POOL_KEYS   = 12;
    localparam int MAX_REPORTS = 40;

    typedef enum logic {ROW_REQ, ROW_CAP} row_kind_t;

    typedef struct packed {
        logic              found;
        logic [DATA_W-1:0] value;
    } lookup_result_t;

    typedef struct {
        row_kind_t         kind;
        logic              op;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic              typed;
        lookup_result_t    result;
    } stim_row_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              op;
    logic [DATA_W-1:0] lookup_key;
    logic [DATA_W-1:0] write_value;
    logic              done;
    logic              found;
    logic [DATA_W-1:0] read_value;
    logic              cfg_wr_en;
    logic [CAP_W-1:0]  cfg_wr_data;

    logic              row_typed;
    lookup_result_t    row_result;

    logic              line_valid [ENTRIES] = '{default: 1'b0};
    logic [DATA_W-1:0] line_key   [ENTRIES] = '{default: '0};
    logic [DATA_W-1:0] line_value [ENTRIES] = '{default: '0};
    int unsigned       line_age   [ENTRIES] = '{default: 0};
    int unsigned       line_count    = 0;
    logic [CAP_W-1:0]  line_capacity = CAP_RESET;

    lookup_result_t    expected_results [$];
    stim_row_t         directed_rows [$];

    int errors      = 0;
    int requests    = 0;
    int hits        = 0;
    int cap_writes  = 0;
    int idle_cycles = 0;

    lru_key_value_cache_core #(
        .ENTRIES (ENTRIES)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .lookup_key  (lookup_key),
        .write_value (write_value),
        .done        (done),
        .found       (found),
        .read_value  (read_value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void promote_line(int slot, int unsigned limit);
        for (int i = 0; i < ENTRIES; i++)
            if (i != slot && line_valid[i] && line_age[i] < limit)
                line_age[i]++;
        line_age[slot] = 0;
    endfunction

    function automatic lookup_result_t lru_access(logic is_put, logic [DATA_W-1:0] key,
                                                  logic [DATA_W-1:0] value);
        lookup_result_t res;
        int hit_slot;
        int victim;
        int free_slot;
        int unsigned cap;
        res.found = 1'b0;
        res.value = MISS_VALUE;
        hit_slot  = -1;
        victim    = -1;
        free_slot = -1;
        cap = (line_capacity == 0) ? 1 :
              (line_capacity > ENTRIES) ? ENTRIES : line_capacity;
        for (int i = 0; i < ENTRIES; i++)
            if (hit_slot < 0 && line_valid[i] && line_key[i] == key)
                hit_slot = i;
        if (hit_slot >= 0)
        begin
            res.found = 1'b1;
            if (is_put == OP_GET)
                res.value = line_value[hit_slot];
            else
                line_value[hit_slot] = value;
            promote_line(hit_slot, line_age[hit_slot]);
        end
        else if (is_put == OP_PUT)
        begin
            if (line_count >= cap)
                for (int i = 0; i < ENTRIES; i++)
                    if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim]))
                        victim = i;
            if (victim >= 0)
            begin
                line_key[victim]   = key;
                line_value[victim] = value;
                promote_line(victim, line_age[victim]);
            end
            else
            begin
                for (int i = 0; i < ENTRIES; i++)
                    if (free_slot < 0 && !line_valid[i])
                        free_slot = i;
                if (free_slot >= 0)
                begin
                    line_valid[free_slot] = 1'b1;
                    line_key[free_slot]   = key;
                    line_value[free_slot] = value;
                    promote_line(free_slot, ENTRIES);
                    line_count++;
                end
            end
        end
        return res;
    endfunction

    function automatic void add_req(logic is_put, logic [DATA_W-1:0] key,
                                    logic [DATA_W-1:0] value);
        stim_row_t row;
        row.kind   = ROW_REQ;
        row.op     = is_put;
        row.key    = key;
        row.value  = value;
        row.typed  = 1'b0;
        row.result = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(logic is_put, logic [DATA_W-1:0] key,
                                        logic [DATA_W-1:0] value, logic exp_found,
                                        logic [DATA_W-1:0] exp_value);
        stim_row_t row;
        row.kind         = ROW_REQ;
        row.op           = is_put;
        row.key          = key;
        row.value        = value;
        row.typed        = 1'b1;
        row.result.found = exp_found;
        row.result.value = exp_value;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_cap(logic [CAP_W-1:0] cap);
        stim_row_t row;
        row.kind   = ROW_CAP;
        row.op     = OP_GET;
        row.key    = '0;
        row.value  = DATA_W'(cap);
        row.typed  = 1'b0;
        row.result = '0;
        directed_rows.push_back(row);
    endfunction

    task automatic report_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic send_request(input logic is_put, input logic [DATA_W-1:0] key,
                                input logic [DATA_W-1:0] value, input logic typed,
                                input lookup_result_t typed_result);
        @(negedge clk);
        start       <= 1'b1;
        op          <= is_put;
        lookup_key  <= key;
        write_value <= value;
        row_typed   <= typed;
        row_result  <= typed_result;
        do
            @(posedge clk);
        while (busy);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    always @(posedge clk)
    begin : result_check
        lookup_result_t want;
        lookup_result_t predicted;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
                report_error($sformatf("result with no request pending: found=%0b value=%h",
                                       found, read_value));
            else
            begin
                want = expected_results.pop_front();
                if (found !== want.found)
                    report_error($sformatf("found mismatch: got %0b, want %0b",
                                           found, want.found));
                if (read_value !== want.value)
                    report_error($sformatf("read_value mismatch: got %h, want %h",
                                           read_value, want.value));
                if (found === 1'b1)
                    hits++;
            end
        end
        if (rst_n && start && !busy)
        begin
            predicted = lru_access(op, lookup_key, write_value);
            expected_results.push_back(row_typed ? row_result : predicted);
            requests++;
        end
        if (rst_n && cfg_wr_en)
        begin
            line_capacity = cfg_wr_data;
            cap_writes++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
                     idle_cycles, expected_results.size());
            $display("FAIL lru_key_value_cache_core");
            $finish;
        end
    end

    initial
    begin
        logic [DATA_W-1:0] key_pool [POOL_KEYS];
        logic [DATA_W-1:0] key;
        logic [CAP_W-1:0]  cap;
        int                gap_pct;
        int                pool_used;

        rst_n       = 1'b0;
        start       = 1'b0;
        op          = OP_GET;
        lookup_key  = '0;
        write_value = '0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        row_typed   = 1'b0;
        row_result  = '0;

        add_checked(OP_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, MISS_VALUE);
        add_checked(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, MISS_VALUE);
        add_checked(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h8000_0000);
        add_checked(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, MISS_VALUE);
        add_checked(OP_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF);
        add_checked(OP_PUT, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, MISS_VALUE);
        add_checked(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF);
        add_checked(OP_GET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, MISS_VALUE);
        add_checked(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, MISS_VALUE);
        add_checked(OP_GET, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 32'h0000_0000);
        add_req(OP_PUT, 32'd1, 32'd11);
        add_req(OP_PUT, 32'd2, 32'd22);
        add_cap(CAP_W'(2));
        add_req(OP_PUT, 32'd3, 32'd33);
        add_req(OP_GET, 32'h7FFF_FFFF, 32'd0);
        add_req(OP_PUT, 32'd4, 32'd44);
        add_req(OP_GET, 32'd1, 32'd0);
        add_req(OP_GET, 32'd2, 32'd0);
        add_req(OP_GET, 32'd3, 32'd0);
        add_req(OP_GET, 32'd4, 32'd0);
        add_cap(CAP_W'(0));
        add_req(OP_PUT, 32'd5, 32'd55);
        add_req(OP_GET, 32'd4, 32'd0);
        add_req(OP_PUT, 32'd6, 32'd66);
        add_req(OP_GET, 32'd5, 32'd0);
        add_cap(CAP_W'(31));
        add_req(OP_PUT, 32'd7, 32'd77);
        add_req(OP_GET, 32'd6, 32'd0);
        add_req(OP_GET, 32'd7, 32'd0);

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_CAP)
                write_capacity(directed_rows[i].value[CAP_W-1:0]);
            else
                send_request(directed_rows[i].op, directed_rows[i].key,
                             directed_rows[i].value, directed_rows[i].typed,
                             directed_rows[i].result);
        end

        for (int p = 0; p < PHASES; p++)
        begin
            unique case (p)
                0: cap = CAP_W'(16);
                1: cap = CAP_W'(1);
                2: cap = CAP_W'(3);
                3: cap = CAP_W'(0);
                4: cap = CAP_W'(31);
                6: cap = CAP_W'(8);
                7: cap = CAP_W'(2);
                default: cap = CAP_W'($urandom_range(31));
            endcase
            write_capacity(cap);
            gap_pct   = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 69 : 10;
            pool_used = $urandom_range(POOL_KEYS, 2);
            for (int k = 0; k < POOL_KEYS; k++)
                key_pool[k] = $urandom;
            for (int n = 0; n < PHASE_REQS; n++)
            begin
                while ($urandom_range(99) < gap_pct)
                begin
                    @(negedge clk);
                    start <= 1'b0;
                end
                key = ($urandom_range(99) < 80) ? key_pool[$urandom_range(pool_used - 1)]
                                                : $urandom;
                send_request(1'($urandom_range(1)), key, $urandom, 1'b0, '0);
            end
        end

        @(negedge clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        $display("covered %0d requests (%0d hits) across %0d capacity writes,",
                 requests, hits, cap_writes);
        $display("including capacities 0, 1, 2, 3, 8, 16 and 31 with gapped traffic");
        if (errors == 0)
            $display("PASS lru_key_value_cache_core");
        else
            $display("FAIL lru_key_value_cache_core");
        $finish;
    end

endmodule
